### sv/tcw_pkg.sv
// tcw_pkg: shared constants, types and helpers for the text console writer.
// Screen geometry, opcode codes, cell layout and the RAM request bundle.
// No dependencies.
package tcw_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 60;
    localparam int CELLS  = ROWS * COLS;
    localparam int COPY_N = (ROWS - 1) * COLS;
    localparam int ADDR_W = $clog2(CELLS);

    localparam int COL_W  = 7;   // col_in / cursor_col field
    localparam int ROW_W  = 6;   // row_in / cursor_row field
    localparam int CROW_W = 7;   // internal cursor row, holds ROWS when a scroll is pending

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] RESET_ATTR   = 8'h0F;
    localparam logic [7:0] BLANK_CHAR   = 8'h00;

    // screen RAM request bundle: one write port and one read port
    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [15:0]       wdata;
    } mem_req_t;

    typedef struct packed {
        logic        go;
        logic        scroll;  // 1: shift rows up then blank bottom row, 0: fill all
        logic [15:0] fill;
    } sweep_cmd_t;

    typedef struct packed {
        logic busy;
    } sweep_stat_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        return ADDR_W'(int'(row) * COLS + int'(col));
    endfunction

endpackage

### sv/text_console_writer_unit.sv
// text_console_writer_unit: text screen of char/attribute cells with a cursor.
// set_cursor only moves the cursor; put_char writes one cell (a newline writes none);
// read_cell reads one cell (none when out of range); a scroll or clear adds one cell sweep.
// One transaction at a time; busy falls in the cycle its result is strobed. Results
// cannot be stalled. Reset is async active low; after it a clearing pass holds busy
// until its sweep ends. Depends on tcw_pkg, tcw_sweep and tcw_screen_ram.
module text_console_writer_unit
    import tcw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // item transaction
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       opcode,
    input  logic [7:0]       char_code,
    input  logic [COL_W-1:0] col_in,
    input  logic [ROW_W-1:0] row_in,
    // result transaction
    output logic             done,
    output logic [COL_W-1:0] cursor_col,
    output logic [ROW_W-1:0] cursor_row,
    output logic [7:0]       cell_char,
    output logic [7:0]       cell_attr,
    output logic             scrolled,
    // attribute register
    input  logic             attr_we,
    input  logic [7:0]       attr_wdata
);

    // sequencer states
    localparam logic [2:0] S_INIT       = 3'd0;  // start reset clearing sweep
    localparam logic [2:0] S_INIT_WAIT  = 3'd1;
    localparam logic [2:0] S_IDLE       = 3'd2;
    localparam logic [2:0] S_SWEEP      = 3'd3;  // kick scroll or clear sweep
    localparam logic [2:0] S_SWEEP_WAIT = 3'd4;
    localparam logic [2:0] S_WRITE      = 3'd5;  // single cell write for put_char
    localparam logic [2:0] S_READ       = 3'd6;
    localparam logic [2:0] S_RESP       = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [7:0]        attr_reg;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [CROW_W-1:0] cur_row_reg, cur_row_next;

    // latched per-transaction context
    logic              scroll_op_reg, scroll_op_next;  // sweep kind
    logic              need_wr_reg,   need_wr_next;
    logic [7:0]        wr_char_reg,   wr_char_next;
    logic [ROW_W-1:0]  pos_row_reg,   pos_row_next;
    logic [COL_W-1:0]  pos_col_reg,   pos_col_next;

    logic [7:0]        res_char_reg,  res_char_next;
    logic [7:0]        res_attr_reg,  res_attr_next;
    logic              res_scr_reg,   res_scr_next;
    logic              done_reg,      done_next;
    // a read result is captured when the read state preceded the response state
    logic              read_issued_reg;

    logic              accept;
    logic [ADDR_W-1:0] pos_addr;
    logic [15:0]       rdata;
    mem_req_t          top_req, sweep_req, mem_req;
    sweep_cmd_t        sweep_cmd;
    sweep_stat_t       sweep_stat;

    // put_char cursor math, all on 8-bit values so COLS/ROWS up to 128/64 compare cleanly
    logic       is_nl, do_scroll;
    logic [7:0] row_a, row_b, col_a, col_b, col_c;
    logic [7:0] put_row, put_col;
    logic       rd_in_range;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    always_comb
    begin
        is_nl     = (char_code == NEWLINE_CODE);
        row_a     = {1'b0, cur_row_reg} + {7'd0, is_nl};
        col_a     = is_nl ? 8'd0 : {1'b0, cur_col_reg};
        do_scroll = (row_a >= 8'(ROWS));
        row_b     = do_scroll ? 8'(ROWS - 1) : row_a;
        col_b     = (col_a >= 8'(COLS)) ? 8'(COLS - 1) : col_a;
        col_c     = col_b + 8'd1;
        put_col   = col_b;
        put_row   = row_b;
        if (!is_nl)
        begin
            // wrap exactly at COLS; the row may land on ROWS, leaving a scroll pending
            if (col_c >= 8'(COLS))
            begin
                put_col = 8'd0;
                put_row = row_b + 8'd1;
            end
            else
            begin
                put_col = col_c;
            end
        end
        rd_in_range = ({1'b0, col_in} < 8'(COLS)) && ({2'b00, row_in} < 8'(ROWS));
    end

    assign pos_addr = cell_addr(pos_row_reg, pos_col_reg);

    always_comb
    begin
        state_next     = state_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        scroll_op_next = scroll_op_reg;
        need_wr_next   = need_wr_reg;
        wr_char_next   = wr_char_reg;
        pos_row_next   = pos_row_reg;
        pos_col_next   = pos_col_reg;
        res_char_next  = res_char_reg;
        res_attr_next  = res_attr_reg;
        res_scr_next   = res_scr_reg;
        done_next      = 1'b0;
        sweep_cmd.go     = 1'b0;
        sweep_cmd.scroll = scroll_op_reg;
        sweep_cmd.fill   = {attr_reg, BLANK_CHAR};
        top_req        = '0;
        top_req.raddr  = pos_addr;
        top_req.waddr  = pos_addr;
        top_req.wdata  = {attr_reg, wr_char_reg};

        unique case (state_reg)
            S_INIT:
            begin
                sweep_cmd.go     = 1'b1;
                sweep_cmd.scroll = 1'b0;
                sweep_cmd.fill   = {RESET_ATTR, BLANK_CHAR};
                state_next       = S_INIT_WAIT;
            end
            S_INIT_WAIT:
            begin
                if (!sweep_stat.busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    res_char_next = 8'd0;
                    res_attr_next = 8'd0;
                    res_scr_next  = 1'b0;
                    unique case (opcode)
                        OP_PUT:
                        begin
                            res_scr_next   = do_scroll;
                            scroll_op_next = 1'b1;
                            need_wr_next   = !is_nl;
                            wr_char_next   = char_code;
                            pos_row_next   = row_b[ROW_W-1:0];
                            pos_col_next   = col_b[COL_W-1:0];
                            cur_row_next   = put_row[CROW_W-1:0];
                            cur_col_next   = put_col[COL_W-1:0];
                            if (do_scroll)
                            begin
                                state_next = S_SWEEP;
                            end
                            else if (!is_nl)
                            begin
                                state_next = S_WRITE;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        OP_SET:
                        begin
                            cur_col_next = ({1'b0, col_in} >= 8'(COLS)) ?
                                           COL_W'(COLS - 1) : col_in;
                            cur_row_next = ({2'b00, row_in} >= 8'(ROWS)) ?
                                           CROW_W'(ROWS - 1) : {1'b0, row_in};
                            state_next   = S_RESP;
                        end
                        OP_CLEAR:
                        begin
                            scroll_op_next = 1'b0;
                            need_wr_next   = 1'b0;
                            cur_col_next   = '0;
                            cur_row_next   = '0;
                            state_next     = S_SWEEP;
                        end
                        OP_READ:
                        begin
                            pos_row_next = row_in;
                            pos_col_next = col_in;
                            state_next   = rd_in_range ? S_READ : S_RESP;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                sweep_cmd.go = 1'b1;
                state_next   = S_SWEEP_WAIT;
            end
            S_SWEEP_WAIT:
            begin
                if (!sweep_stat.busy)
                begin
                    state_next = need_wr_reg ? S_WRITE : S_RESP;
                end
            end
            S_WRITE:
            begin
                top_req.we = 1'b1;
                state_next = S_RESP;
            end
            S_READ:
            begin
                // issue read; S_RESP sees the registered data
                top_req.re = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            attr_reg    <= RESET_ATTR;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            done_reg    <= 1'b0;
            res_char_reg <= '0;
            res_attr_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            done_reg    <= done_next;
            if (attr_we)
            begin
                attr_reg <= attr_wdata;
            end
            if (state_reg == S_RESP && read_issued_reg)
            begin
                res_char_reg <= rdata[7:0];
                res_attr_reg <= rdata[15:8];
            end
            else
            begin
                res_char_reg <= res_char_next;
                res_attr_reg <= res_attr_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_issued_reg <= 1'b0;
        end
        else
        begin
            read_issued_reg <= (state_reg == S_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        scroll_op_reg <= scroll_op_next;
        need_wr_reg   <= need_wr_next;
        wr_char_reg   <= wr_char_next;
        pos_row_reg   <= pos_row_next;
        pos_col_reg   <= pos_col_next;
        res_scr_reg   <= res_scr_next;
    end

    // RAM ports belong to the sweep unit while it runs
    assign mem_req = sweep_stat.busy ? sweep_req : top_req;

    tcw_sweep u_sweep (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (sweep_cmd),
        .rdata (rdata),
        .stat  (sweep_stat),
        .req   (sweep_req)
    );

    tcw_screen_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    assign done       = done_reg;
    assign cursor_col = cur_col_reg;
    assign cursor_row = cur_row_reg[ROW_W-1:0];
    assign cell_char  = res_char_reg;
    assign cell_attr  = res_attr_reg;
    assign scrolled   = res_scr_reg;

endmodule

### sv/tcw_screen_ram.sv
// tcw_screen_ram: character/attribute cell store, one write and one read port.
// Read data is registered. Depends on tcw_pkg.
module tcw_screen_ram
    import tcw_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output logic [15:0] rdata
);

    logic [15:0] mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

### sv/tcw_sweep.sv
// tcw_sweep: walks every cell once, for a fill or a scroll-up row copy.
// One address counter plus one write stage behind the registered RAM read.
// Depends on tcw_pkg.
module tcw_sweep
    import tcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sweep_cmd_t  cmd,
    input  logic [15:0] rdata,
    output sweep_stat_t stat,
    output mem_req_t    req
);

    logic              issue_reg,  issue_next;
    logic              scroll_reg, scroll_next;
    logic [15:0]       fill_reg,   fill_next;
    logic [ADDR_W-1:0] idx_reg,    idx_next;
    logic              st_valid_reg, st_valid_next;
    logic              st_copy_reg,  st_copy_next;
    logic [ADDR_W-1:0] st_idx_reg,   st_idx_next;
    logic              copy_now;

    // in a scroll, cells above the last row take data from one row further down
    assign copy_now = scroll_reg && (idx_reg < ADDR_W'(COPY_N));

    always_comb
    begin
        issue_next    = issue_reg;
        scroll_next   = scroll_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        st_valid_next = 1'b0;
        st_copy_next  = st_copy_reg;
        st_idx_next   = st_idx_reg;
        if (cmd.go)
        begin
            issue_next  = 1'b1;
            scroll_next = cmd.scroll;
            fill_next   = cmd.fill;
            idx_next    = '0;
        end
        else if (issue_reg)
        begin
            st_valid_next = 1'b1;
            st_copy_next  = copy_now;
            st_idx_next   = idx_reg;
            idx_next      = idx_reg + ADDR_W'(1);
            if (idx_reg == ADDR_W'(CELLS - 1))
            begin
                issue_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg    <= 1'b0;
            st_valid_reg <= 1'b0;
        end
        else
        begin
            issue_reg    <= issue_next;
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scroll_reg  <= scroll_next;
        fill_reg    <= fill_next;
        idx_reg     <= idx_next;
        st_copy_reg <= st_copy_next;
        st_idx_reg  <= st_idx_next;
    end

    always_comb
    begin
        req.re    = issue_reg && copy_now;
        req.raddr = idx_reg + ADDR_W'(COLS);
        req.we    = st_valid_reg;
        req.waddr = st_idx_reg;
        req.wdata = st_copy_reg ? rdata : fill_reg;
    end

    assign stat.busy = issue_reg || st_valid_reg;

endmodule

### sv/tcw_checker.sv
// tcw_checker: port-level checks on the text console writer over time.
// Bound to text_console_writer_unit. No package dependency.
module tcw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [7:0] cell_char,
    input logic [7:0] cell_attr,
    input logic       scrolled
);

    // an accepted transaction raises busy in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // results only come out once the unit is free again
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done strobed while busy");

    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held longer than one cycle");

    // only put_char scrolls, and it never reports cell contents
    assert property (@(posedge clk) disable iff (!rst_n)
                     (done && scrolled) |-> (cell_char == 8'd0 && cell_attr == 8'd0))
        else $error("scroll result carries cell data");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cell_char (cell_char),
    .cell_attr (cell_attr),
    .scrolled  (scrolled)
);

### sim/text_console_writer_unit_tb.sv
// Self-checking testbench for text_console_writer_unit: directed and random
// put_char/set_cursor/clear_screen/read_cell traffic against a cycle-free screen model.
// Depends on tcw_pkg and the RTL of text_console_writer_unit only.
module text_console_writer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    // Longest legal silence is one cell sweep (reset clear, scroll or clear) plus
    // the longest sender gap; the limit is several times that.
    localparam int WATCHDOG_LIMIT = 30000;
    // Cycles to keep watching for stray strobes once every result is in.
    localparam int LINGER_CYCLES  = 20;

    // One result transaction as seen on the output ports.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [7:0]       chr;
        logic [7:0]       attr;
        logic             scr;
    } cursor_report_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       opcode;
    logic [7:0]       char_code;
    logic [COL_W-1:0] col_in;
    logic [ROW_W-1:0] row_in;
    logic             done;
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
    logic             scrolled;
    logic             attr_we;
    logic [7:0]       attr_wdata;

    text_console_writer_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .char_code  (char_code),
        .col_in     (col_in),
        .row_in     (row_in),
        .done       (done),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .cell_char  (cell_char),
        .cell_attr  (cell_attr),
        .scrolled   (scrolled),
        .attr_we    (attr_we),
        .attr_wdata (attr_wdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Screen model: a shadow copy of the cell store, the cursor and the
    // attribute register. The row is one bit wider than the port so that
    // the "scroll pending" row (== ROWS) can be held.
    // ------------------------------------------------------------------
    logic [15:0]       screen_copy [CELLS];
    logic [COL_W-1:0]  model_col;
    logic [CROW_W-1:0] model_row;
    logic [7:0]        model_attr;
    logic [COL_W-1:0]  last_put_col;
    logic [ROW_W-1:0]  last_put_row;

    cursor_report_t cursor_reports [$];   // results still owed by the DUT

    int  items_sent;
    int  results_checked;
    int  scrolls_seen;
    int  attr_settings;
    int  mismatches;
    int  stall_cycles;
    bit  gaps_on;

    function automatic void model_reset();
        model_attr = RESET_ATTR;
        for (int i = 0; i < CELLS; i++)
            screen_copy[i] = {RESET_ATTR, BLANK_CHAR};
        model_col    = '0;
        model_row    = '0;
        last_put_col = '0;
        last_put_row = '0;
    endfunction

    // Move rows 1..ROWS-1 up by one; the freed bottom row takes the current attribute.
    function automatic void model_scroll_up();
        for (int i = 0; i < COPY_N; i++)
            screen_copy[i] = screen_copy[i + COLS];
        for (int i = 0; i < COLS; i++)
            screen_copy[COPY_N + i] = {model_attr, BLANK_CHAR};
    endfunction

    // Applies one accepted command to the model and returns the result it owes.
    function automatic cursor_report_t console_apply(input logic [1:0]       op,
                                                     input logic [7:0]       ch,
                                                     input logic [COL_W-1:0] col,
                                                     input logic [ROW_W-1:0] row);
        cursor_report_t r;
        r = '0;
        case (op)
            OP_PUT:
            begin
                // newline steps down first; a scroll (pending or caused by the
                // newline) is taken before any character lands
                if (ch == NEWLINE_CODE)
                begin
                    model_row = model_row + 1'b1;
                    model_col = '0;
                end
                if (int'(model_row) >= ROWS)
                begin
                    model_scroll_up();
                    model_row = CROW_W'(ROWS - 1);
                    r.scr     = 1'b1;
                end
                if (ch != NEWLINE_CODE)
                begin
                    if (int'(model_col) >= COLS)
                        model_col = COL_W'(COLS - 1);
                    screen_copy[int'(model_row) * COLS + int'(model_col)] = {model_attr, ch};
                    last_put_col = model_col;
                    last_put_row = model_row[ROW_W-1:0];
                    // wrap exactly at COLS; may leave the row at ROWS (pending)
                    if (int'(model_col) + 1 >= COLS)
                    begin
                        model_col = '0;
                        model_row = model_row + 1'b1;
                    end
                    else
                        model_col = model_col + 1'b1;
                end
            end
            OP_SET:
            begin
                model_col = (int'(col) >= COLS) ? COL_W'(COLS - 1) : col;
                model_row = (int'(row) >= ROWS) ? CROW_W'(ROWS - 1) : CROW_W'(row);
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen_copy[i] = {model_attr, BLANK_CHAR};
                model_col = '0;
                model_row = '0;
            end
            OP_READ:
            begin
                // out-of-range reads return zeros
                if (int'(col) < COLS && int'(row) < ROWS)
                    {r.attr, r.chr} = screen_copy[int'(row) * COLS + int'(col)];
            end
        endcase
        r.col = model_col;
        r.row = model_row[ROW_W-1:0];   // pending row shows as ROWS on the port
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every strobe is matched to the oldest expectation.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input logic [7:0] got);
        if (got !== 8'(want))
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        cursor_report_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (cursor_reports.size() == 0)
            begin
                $display("%0t: result strobed with none outstanding: col %0d row %0d",
                         $time, cursor_col, cursor_row);
                $display("    char %0d attr %0d scrolled %0b",
                         cell_char, cell_attr, scrolled);
                mismatches++;
            end
            else
            begin
                want = cursor_reports.pop_front();
                check_field("cursor_col", want.col,  8'(cursor_col));
                check_field("cursor_row", want.row,  8'(cursor_row));
                check_field("cell_char",  want.chr,  cell_char);
                check_field("cell_attr",  want.attr, cell_attr);
                check_field("scrolled",   want.scr,  8'(scrolled));
                results_checked++;
                if (want.scr)
                    scrolls_seen++;
            end
        end
    end

    // Watchdog: any cycle with neither a command nor a result accepted counts.
    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog: no transaction for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, cursor_reports.size());
            $display("TEST FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Mostly back-to-back or short gaps, now and then a long one.
    task automatic sender_gap();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            n = 0;
        else if (pick < 85)
            n = $urandom_range(1, 3);
        else if (pick < 97)
            n = $urandom_range(4, 20);
        else
            n = $urandom_range(50, 300);
        repeat (n) @(negedge clk);
    endtask

    // One command transaction: drive at the falling edge, hold until taken.
    task automatic send_item(input logic [1:0]       op,
                             input logic [7:0]       ch,
                             input logic [COL_W-1:0] col,
                             input logic [ROW_W-1:0] row);
        if (gaps_on)
            sender_gap();
        @(negedge clk);
        opcode    <= op;
        char_code <= ch;
        col_in    <= col;
        row_in    <= row;
        start     <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        cursor_reports.push_back(console_apply(op, ch, col, row));
        items_sent++;
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Unused fields get random values so every input bit toggles.
    task automatic put_char(input logic [7:0] ch);
        send_item(OP_PUT, ch, COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 63)));
    endtask

    task automatic set_cursor(input int col, input int row);
        send_item(OP_SET, 8'($urandom_range(0, 255)), COL_W'(col), ROW_W'(row));
    endtask

    task automatic read_cell(input int col, input int row);
        send_item(OP_READ, 8'($urandom_range(0, 255)), COL_W'(col), ROW_W'(row));
    endtask

    task automatic clear_screen();
        send_item(OP_CLEAR, 8'($urandom_range(0, 255)),
                  COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 63)));
    endtask

    // Hold off until the DUT owes nothing and has dropped busy.
    task automatic wait_until_drained();
        while (cursor_reports.size() != 0)
            @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    // Attribute register write; only called with the DUT idle.
    task automatic write_attribute(input logic [7:0] value);
        wait_until_drained();
        @(negedge clk);
        attr_we    <= 1'b1;
        attr_wdata <= value;
        @(negedge clk);
        attr_we    <= 1'b0;
        model_attr = value;
        attr_settings++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Store is cleared to char 0 / attr 0x0F at reset; reads past the edges give zeros.
    task automatic test_power_up_contents();
        read_cell(0, 0);
        read_cell(COLS - 1, ROWS - 1);
        read_cell(COLS, 0);
        read_cell(127, 63);
        read_cell(0, ROWS);
    endtask

    // set_cursor saturates each coordinate on its own.
    task automatic test_cursor_saturation();
        set_cursor(127, 63);
        set_cursor(0, 0);
    endtask

    // Write at the last two columns, wrap to the next row, then newline.
    task automatic test_put_wrap_newline();
        write_attribute(8'hFF);
        set_cursor(COLS - 2, 3);
        put_char(8'hFF);
        put_char(8'h00);
        put_char(NEWLINE_CODE);
        read_cell(COLS - 2, 3);
        read_cell(COLS - 1, 3);
    endtask

    // Wrap off the bottom leaves a pending scroll; the next char takes it.
    // A newline on the last row scrolls at once; a newline while pending
    // scrolls only once.
    task automatic test_scroll_cases();
        write_attribute(8'h00);
        set_cursor(COLS - 2, ROWS - 1);
        put_char("A");
        put_char("B");
        read_cell(COLS - 1, ROWS - 1);
        put_char("C");
        read_cell(COLS - 1, ROWS - 2);
        put_char(NEWLINE_CODE);
        set_cursor(COLS - 1, ROWS - 1);
        put_char("D");
        put_char(NEWLINE_CODE);
    endtask

    // Clear uses the current attribute and homes the cursor.
    task automatic test_clear_screen();
        write_attribute(8'hA5);
        clear_screen();
        read_cell(COLS / 2, ROWS / 2);
    endtask

    function automatic logic [7:0] pick_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return NEWLINE_CODE;
        else if (pick < 20)
            return 8'h00;
        else if (pick < 25)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Reads often hit what was just written; some go past the edges.
    task automatic random_read();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            read_cell(last_put_col, last_put_row);
        else if (pick < 48)
            read_cell($urandom_range(COLS, 127), $urandom_range(0, 63));
        else if (pick < 55)
            read_cell($urandom_range(0, 127), $urandom_range(ROWS, 63));
        else
            read_cell($urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1));
    endtask

    // A burst: maybe reposition (biased to the bottom rows so scrolls happen
    // often), a run of characters, then one or two reads. A clear now and then.
    task automatic random_burst();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            clear_screen();
        else if (pick < 50)
        begin
            if ($urandom_range(0, 99) < 60)
                set_cursor($urandom_range(0, 99) < 70 ? $urandom_range(0, COLS - 1)
                                                     : $urandom_range(COLS - 6, 127),
                           $urandom_range(ROWS - 4, 63));
            else
                set_cursor($urandom_range(0, 127), $urandom_range(0, 63));
        end
        repeat ($urandom_range(1, 10))
            put_char(pick_char());
        repeat ($urandom_range(1, 2))
            random_read();
    endtask

    task automatic random_phase(input int n_items, input logic [7:0] attr, input bit gaps);
        int target;
        write_attribute(attr);   // drains first, so the sender pauses here
        gaps_on = gaps;
        target  = items_sent + n_items;
        while (items_sent < target)
            random_burst();
    endtask

    task automatic test_random_traffic();
        random_phase(30, 8'($urandom_range(1, 254)), 1'b1);
        random_phase(20, 8'hFF, 1'b0);            // no idling at all in this one
        random_phase(35, 8'($urandom_range(0, 255)), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        opcode          = OP_PUT;
        char_code       = '0;
        col_in          = '0;
        row_in          = '0;
        attr_we         = 1'b0;
        attr_wdata      = '0;
        items_sent      = 0;
        results_checked = 0;
        scrolls_seen    = 0;
        attr_settings   = 1;          // the reset value counts as one setting
        mismatches      = 0;
        stall_cycles    = 0;
        gaps_on         = 1'b1;
        model_reset();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // the clearing pass after reset keeps busy high
        do
            @(posedge clk);
        while (busy !== 1'b0);

        test_power_up_contents();
        test_cursor_saturation();
        test_put_wrap_newline();
        test_scroll_cases();
        test_clear_screen();
        test_random_traffic();

        wait_until_drained();
        repeat (LINGER_CYCLES) @(posedge clk);

        $display("Ran %0d commands (put/newline/wrap, set_cursor, clear, read)",
                 items_sent);
        $display("over %0d attribute values.", attr_settings);
        $display("Checked %0d results, %0d of them with a scroll; %0d field mismatches.",
                 results_checked, scrolls_seen, mismatches);
        if (mismatches == 0 && cursor_reports.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
sv/tcw_pkg.sv
sv/tcw_screen_ram.sv
sv/tcw_sweep.sv
sv/text_console_writer_unit.sv
sv/tcw_checker.sv
sim/text_console_writer_unit_tb.sv
